>>> design/rk4rlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rk4rlc_pkg
// Shared types, register indexes and saturating helpers for the RK4 RLC step.
// ----------------------------------------------------------------------------
package rk4rlc_pkg;

    localparam int CFG_DATA_W  = 63;
    localparam int CFG_INDEX_W = 3;
    localparam int PHASE_STEP_W = 31;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIME_STEP      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_INDUCTANCE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_LC         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_R_OVER_L       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_AMP      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP     = 3'd5;

    localparam logic [62:0] RST_TIME_STEP      = 63'd4294967;
    localparam logic [62:0] RST_INV_INDUCTANCE = 63'd42949672960;
    localparam logic [62:0] RST_INV_LC         = 63'd42949672960000;
    localparam logic [62:0] RST_R_OVER_L       = 63'd4294967296000;
    localparam logic [62:0] RST_DRIVE_AMP      = 63'd42949672960;
    localparam logic [30:0] RST_PHASE_STEP     = 31'd34177904;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

    // pi/2 in unsigned Q2.62
    localparam logic [63:0] PI_HALF_Q62 = 64'h6487_ED51_10B4_611A;

    localparam logic [1:0] STAGE_K1 = 2'd0;
    localparam logic [1:0] STAGE_K2 = 2'd1;
    localparam logic [1:0] STAGE_K3 = 2'd2;
    localparam logic [1:0] STAGE_K4 = 2'd3;

    typedef struct packed {
        logic               start;
        logic               sh30;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [63:0] p;
    } mul_rsp_t;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_DT6  = 12'b0000_0000_0010,
        ST_V0   = 12'b0000_0000_0100,
        ST_VH   = 12'b0000_0000_1000,
        ST_V1   = 12'b0000_0001_0000,
        ST_KQ   = 12'b0000_0010_0000,
        ST_KI   = 12'b0000_0100_0000,
        ST_SL_V = 12'b0000_1000_0000,
        ST_SL_Q = 12'b0001_0000_0000,
        ST_SL_I = 12'b0010_0000_0000,
        ST_FQ   = 12'b0100_0000_0000,
        ST_FI   = 12'b1000_0000_0000
    } seq_state_t;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_PP   = 4'b0010,
        M_NEG  = 4'b0100,
        M_SAT  = 4'b1000
    } mul_state_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? SAT_MIN : SAT_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? SAT_MIN : SAT_MAX;
        return s[63:0];
    endfunction

    // running 1-2-2-1 weighted sum, left to right
    function automatic logic signed [63:0] weigh_step(input logic signed [63:0] sum,
                                                      input logic signed [63:0] k,
                                                      input logic [1:0] stage);
        logic signed [63:0] r;
        case (stage)
            STAGE_K1: r = k;
            STAGE_K2: r = sat_add(sum, sat_add(k, k));
            STAGE_K3: r = sat_add(sum, sat_add(k, k));
            default:  r = sat_add(sum, k);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/rk4rlc_sine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rk4rlc_sine
// Quarter-wave sine lookup, Q1.30, nearest entry; read through an index register and a ROM register.
// ----------------------------------------------------------------------------
module rk4rlc_sine
    import rk4rlc_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  wire logic               clk,
    input  wire logic [31:0]        phase,
    output logic signed [31:0]      sine
);

    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = 30 + IW;

    typedef logic [30:0] rom_t [0:SINE_TABLE_DEPTH];

    function automatic rom_t build_rom();
        logic [63:0]  step_v;
        logic [63:0]  rem_v;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  tmp;
        logic [127:0] p;
        rom_t         r;
        step_v = PI_HALF_Q62 / 64'(SINE_TABLE_DEPTH);
        rem_v  = PI_HALF_Q62 % 64'(SINE_TABLE_DEPTH);
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = step_v * 64'(k) + (rem_v * 64'(k)) / 64'(SINE_TABLE_DEPTH);
            p    = {64'd0, x} * {64'd0, x};
            x2   = p[125:62];
            term = x;
            sum  = x;
            for (int n = 1; n <= 12; n++) begin
                p    = {64'd0, term} * {64'd0, x2};
                term = p[125:62] / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            tmp  = sum + 64'h8000_0000;
            r[k] = tmp[62:32];
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [PW-1:0] scaled;
    logic [IW-1:0] idx_raw;
    logic [IW-1:0] idx_clamp;
    logic [IW-1:0] idx;
    logic [IW-1:0] idx_reg;
    logic          neg_reg;
    logic [30:0]   rom_reg;
    logic          neg2_reg;

    always_comb
    begin
        scaled    = PW'(phase[29:0]) * PW'(SINE_TABLE_DEPTH) + PW'(64'd1 << 29);
        idx_raw   = scaled[PW-1:30];
        idx_clamp = (idx_raw > IW'(SINE_TABLE_DEPTH)) ? IW'(SINE_TABLE_DEPTH) : idx_raw;
        // odd quadrants run the table backwards
        idx       = phase[30] ? IW'(SINE_TABLE_DEPTH) - idx_clamp : idx_clamp;
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx;
        neg_reg  <= phase[31];
        rom_reg  <= SINE_ROM[idx_reg];
        neg2_reg <= neg_reg;
    end

    assign sine = neg2_reg ? -$signed({1'b0, rom_reg}) : $signed({1'b0, rom_reg});

endmodule
`default_nettype wire

>>> design/rk4rlc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rk4rlc_mul
// Shared signed 64x64 multiplier: four 32x32 partial products, floor shift,
// saturation to 64 bits.
// ----------------------------------------------------------------------------
module rk4rlc_mul
    import rk4rlc_pkg::*;
#(
    parameter int FRACTION_BITS = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    mul_state_t     mstate_reg, mstate_next;
    logic [1:0]     pp_reg, pp_next;
    logic           done_reg, done_next;
    logic [63:0]    ua_reg;
    logic [63:0]    ub_reg;
    logic           neg_reg;
    logic           sh30_reg;
    logic [127:0]   acc_reg, acc_next;
    logic [63:0]    res_reg, res_next;

    logic [31:0]    a_half;
    logic [31:0]    b_half;
    logic [63:0]    part;
    logic [127:0]   part_sh;
    logic [127:0]   shifted;
    logic           fits;

    always_comb
    begin
        a_half = pp_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        b_half = pp_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        part   = {32'd0, a_half} * {32'd0, b_half};
        case (pp_reg)
            2'd0:    part_sh = {64'd0, part};
            2'd3:    part_sh = {part, 64'd0};
            default: part_sh = {32'd0, part, 32'd0};
        endcase
        shifted = sh30_reg ? 128'($signed(acc_reg) >>> 30)
                           : 128'($signed(acc_reg) >>> FRACTION_BITS);
        fits    = (&shifted[127:63]) | (~|shifted[127:63]);
    end

    always_comb
    begin
        mstate_next = mstate_reg;
        pp_next     = pp_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        res_next    = res_reg;
        case (mstate_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    acc_next    = '0;
                    pp_next     = '0;
                    mstate_next = M_PP;
                end
            end
            M_PP:
            begin
                acc_next = acc_reg + part_sh;
                pp_next  = pp_reg + 2'd1;
                if (pp_reg == 2'd3)
                    mstate_next = M_NEG;
            end
            M_NEG:
            begin
                if (neg_reg)
                    acc_next = -acc_reg;
                mstate_next = M_SAT;
            end
            M_SAT:
            begin
                if (fits)
                    res_next = shifted[63:0];
                else
                    res_next = shifted[127] ? SAT_MIN : SAT_MAX;
                done_next   = 1'b1;
                mstate_next = M_IDLE;
            end
            default:
            begin
                mstate_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mstate_reg <= M_IDLE;
            pp_reg     <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            mstate_reg <= mstate_next;
            pp_reg     <= pp_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        res_reg <= res_next;
        if (mstate_reg == M_IDLE && req.start)
        begin
            ua_reg   <= req.a[63] ? 64'(-req.a) : 64'(req.a);
            ub_reg   <= req.b[63] ? 64'(-req.b) : 64'(req.b);
            neg_reg  <= req.a[63] ^ req.b[63];
            sh30_reg <= req.sh30;
        end
    end

    assign rsp.busy = (mstate_reg != M_IDLE);
    assign rsp.done = done_reg;
    assign rsp.p    = res_reg;

endmodule
`default_nettype wire

>>> design/rk4_driven_rlc_circuit_step.sv
`default_nettype none
// Flow: the result beat is offered in the cycle after the input beat (it is
//   the state before the update); the update itself is 24 multiplies, each
//   (settle, four 32x32 partial products, sign, shift) on one multiplier,
//   and no new input beat is taken until the update is through.
// Reset: charge, current, phase and step count clear; registers take defaults.
// ----------------------------------------------------------------------------
// rk4_driven_rlc_circuit_step
// Driven series RLC circuit advanced one RK4 step per input beat, using a
// sequencer around one shared multiplier and a sine table.
// ----------------------------------------------------------------------------
module rk4_driven_rlc_circuit_step
    import rk4rlc_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int FRACTION_BITS    = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   restart,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [31:0]                 step_index,
    output logic signed [63:0]          charge,
    output logic signed [63:0]          current,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [63:0] SIXTH = ((64'd1 << FRACTION_BITS) + 64'd3) / 64'd6;
    localparam logic [1:0]  SETTLE_DONE = 2'd2;

    logic [62:0] time_step_reg;
    logic [62:0] inv_l_reg;
    logic [62:0] inv_lc_reg;
    logic [62:0] r_over_l_reg;
    logic [62:0] amp_reg;
    logic [30:0] pstep_reg;

    seq_state_t  state_reg, state_next;
    logic [1:0]  stage_reg, stage_next;
    logic [1:0]  settle_reg, settle_next;
    logic        issued_reg, issued_next;
    logic        out_valid_reg, out_valid_next;

    logic signed [63:0] q_reg, q_next;
    logic signed [63:0] i_reg, i_next;
    logic [31:0]        phase_reg, phase_next;
    logic [31:0]        count_reg, count_next;

    logic signed [63:0] dt6_reg, dt6_next;
    logic signed [63:0] v0_reg, v0_next;
    logic signed [63:0] vh_reg, vh_next;
    logic signed [63:0] v1_reg, v1_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] qs_reg, qs_next;
    logic signed [63:0] is_reg, is_next;
    logic signed [63:0] kq_reg, kq_next;
    logic signed [63:0] ki_reg, ki_next;
    logic signed [63:0] kqs_reg, kqs_next;
    logic signed [63:0] kis_reg, kis_next;
    logic [31:0]        step_index_reg, step_index_next;
    logic signed [63:0] charge_reg, charge_next;
    logic signed [63:0] current_reg, current_next;

    logic               in_beat;
    logic [31:0]        sine_phase;
    logic signed [31:0] sine_val;
    logic signed [63:0] dt_s;
    logic signed [63:0] h_s;
    logic signed [63:0] hsel;
    logic signed [63:0] vsel;
    logic signed [63:0] q0;
    logic signed [63:0] i0;
    logic signed [63:0] m;
    mul_req_t           mul_req;
    mul_rsp_t           mul_rsp;

    rk4rlc_sine #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_sine (
        .clk   (clk),
        .phase (sine_phase),
        .sine  (sine_val)
    );

    rk4rlc_mul #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_beat  = in_valid && in_ready;
    assign dt_s     = $signed({1'b0, time_step_reg});
    assign h_s      = $signed({2'b00, time_step_reg[62:1]});
    assign m        = mul_rsp.p;

    always_comb
    begin
        case (stage_reg)
            STAGE_K4: hsel = dt_s;
            default:  hsel = h_s;
        endcase
        case (stage_reg)
            STAGE_K1: vsel = v0_reg;
            STAGE_K4: vsel = v1_reg;
            default:  vsel = vh_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        stage_next      = stage_reg;
        settle_next     = settle_reg;
        issued_next     = issued_reg;
        out_valid_next  = out_valid_reg;
        q_next          = q_reg;
        i_next          = i_reg;
        phase_next      = phase_reg;
        count_next      = count_reg;
        dt6_next        = dt6_reg;
        v0_next         = v0_reg;
        vh_next         = vh_reg;
        v1_next         = v1_reg;
        acc_next        = acc_reg;
        qs_next         = qs_reg;
        is_next         = is_reg;
        kq_next         = kq_reg;
        ki_next         = ki_reg;
        kqs_next        = kqs_reg;
        kis_next        = kis_reg;
        step_index_next = step_index_reg;
        charge_next     = charge_reg;
        current_next    = current_reg;
        q0              = q_reg;
        i0              = i_reg;
        sine_phase      = phase_reg;
        mul_req.start   = 1'b0;
        mul_req.sh30    = 1'b0;
        mul_req.a       = '0;
        mul_req.b       = '0;

        case (state_reg)
            ST_DT6:
            begin
                mul_req.a = dt_s;
                mul_req.b = $signed(SIXTH);
            end
            ST_V0:
            begin
                mul_req.a    = $signed({1'b0, amp_reg});
                mul_req.b    = 64'(sine_val);
                mul_req.sh30 = 1'b1;
            end
            ST_VH:
            begin
                sine_phase   = phase_reg + {1'b0, pstep_reg};
                mul_req.a    = $signed({1'b0, amp_reg});
                mul_req.b    = 64'(sine_val);
                mul_req.sh30 = 1'b1;
            end
            ST_V1:
            begin
                sine_phase   = phase_reg + {pstep_reg, 1'b0};
                mul_req.a    = $signed({1'b0, amp_reg});
                mul_req.b    = 64'(sine_val);
                mul_req.sh30 = 1'b1;
            end
            ST_KQ:
            begin
                mul_req.a = hsel;
                mul_req.b = kq_reg;
            end
            ST_KI:
            begin
                mul_req.a = hsel;
                mul_req.b = ki_reg;
            end
            ST_SL_V:
            begin
                mul_req.a = vsel;
                mul_req.b = $signed({1'b0, inv_l_reg});
            end
            ST_SL_Q:
            begin
                mul_req.a = qs_reg;
                mul_req.b = $signed({1'b0, inv_lc_reg});
            end
            ST_SL_I:
            begin
                mul_req.a = is_reg;
                mul_req.b = $signed({1'b0, r_over_l_reg});
            end
            ST_FQ:
            begin
                mul_req.a = dt6_reg;
                mul_req.b = kqs_reg;
            end
            ST_FI:
            begin
                mul_req.a = dt6_reg;
                mul_req.b = kis_reg;
            end
            default:
            begin
                mul_req.a = '0;
            end
        endcase

        // let the registered sine read settle after a state change before issuing
        if (state_reg != ST_IDLE)
        begin
            if (settle_reg != SETTLE_DONE)
                settle_next = settle_reg + 2'd1;
            else if (!issued_reg)
            begin
                mul_req.start = 1'b1;
                issued_next   = 1'b1;
            end
        end

        if (mul_rsp.done)
        begin
            settle_next = '0;
            issued_next = 1'b0;
            case (state_reg)
                ST_DT6:
                begin
                    dt6_next   = m;
                    state_next = ST_V0;
                end
                ST_V0:
                begin
                    v0_next    = m;
                    state_next = ST_VH;
                end
                ST_VH:
                begin
                    vh_next    = m;
                    state_next = ST_V1;
                end
                ST_V1:
                begin
                    v1_next    = m;
                    stage_next = STAGE_K1;
                    state_next = ST_SL_V;
                end
                ST_KQ:
                begin
                    qs_next    = sat_add(q_reg, m);
                    state_next = ST_KI;
                end
                ST_KI:
                begin
                    is_next    = sat_add(i_reg, m);
                    kq_next    = sat_add(i_reg, m);
                    kqs_next   = weigh_step(kqs_reg, sat_add(i_reg, m), stage_reg);
                    state_next = ST_SL_V;
                end
                ST_SL_V:
                begin
                    acc_next   = m;
                    state_next = ST_SL_Q;
                end
                ST_SL_Q:
                begin
                    acc_next   = sat_sub(acc_reg, m);
                    state_next = ST_SL_I;
                end
                ST_SL_I:
                begin
                    ki_next  = sat_sub(acc_reg, m);
                    kis_next = weigh_step(kis_reg, sat_sub(acc_reg, m), stage_reg);
                    if (stage_reg == STAGE_K4)
                        state_next = ST_FQ;
                    else
                    begin
                        stage_next = stage_reg + 2'd1;
                        state_next = ST_KQ;
                    end
                end
                ST_FQ:
                begin
                    q_next     = sat_add(q_reg, m);
                    state_next = ST_FI;
                end
                ST_FI:
                begin
                    i_next     = sat_add(i_reg, m);
                    phase_next = phase_reg + {pstep_reg, 1'b0};
                    count_next = count_reg + 32'd1;
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (in_beat)
        begin
            if (restart)
            begin
                q0         = '0;
                i0         = '0;
                q_next     = '0;
                i_next     = '0;
                phase_next = '0;
                count_next = '0;
            end
            step_index_next = restart ? 32'd0 : count_reg;
            charge_next     = q0;
            current_next    = i0;
            out_valid_next  = 1'b1;
            qs_next         = q0;
            is_next         = i0;
            kq_next         = i0;
            kqs_next        = i0;
            settle_next     = '0;
            issued_next     = 1'b0;
            state_next      = ST_DT6;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stage_reg     <= STAGE_K1;
            settle_reg    <= '0;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            q_reg         <= '0;
            i_reg         <= '0;
            phase_reg     <= '0;
            count_reg     <= '0;
            time_step_reg <= RST_TIME_STEP;
            inv_l_reg     <= RST_INV_INDUCTANCE;
            inv_lc_reg    <= RST_INV_LC;
            r_over_l_reg  <= RST_R_OVER_L;
            amp_reg       <= RST_DRIVE_AMP;
            pstep_reg     <= RST_PHASE_STEP;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            settle_reg    <= settle_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            q_reg         <= q_next;
            i_reg         <= i_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_TIME_STEP:      time_step_reg <= cfg_data;
                    CFG_INV_INDUCTANCE: inv_l_reg     <= cfg_data;
                    CFG_INV_LC:         inv_lc_reg    <= cfg_data;
                    CFG_R_OVER_L:       r_over_l_reg  <= cfg_data;
                    CFG_DRIVE_AMP:      amp_reg       <= cfg_data;
                    CFG_PHASE_STEP:     pstep_reg     <= cfg_data[PHASE_STEP_W-1:0];
                    default:            pstep_reg     <= pstep_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dt6_reg        <= dt6_next;
        v0_reg         <= v0_next;
        vh_reg         <= vh_next;
        v1_reg         <= v1_next;
        acc_reg        <= acc_next;
        qs_reg         <= qs_next;
        is_reg         <= is_next;
        kq_reg         <= kq_next;
        ki_reg         <= ki_next;
        kqs_reg        <= kqs_next;
        kis_reg        <= kis_next;
        step_index_reg <= step_index_next;
        charge_reg     <= charge_next;
        current_reg    <= current_next;
    end

    assign out_valid  = out_valid_reg;
    assign step_index = step_index_reg;
    assign charge     = charge_reg;
    assign current    = current_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiply issued while busy");

    a_beat_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> state_reg == ST_DT6 && out_valid_reg)
        else $error("input beat did not start a step");

endmodule
`default_nettype wire

>>> tb/sv/rk4_rlc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rk4_rlc_checker
// Tracks register writes and input beats, predicts the reported step of the
// driven RLC RK4 integrator and compares each result beat field by field.
// ----------------------------------------------------------------------------
module rk4_rlc_checker
    import rk4rlc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   restart,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [31:0]            step_index,
    input  logic signed [63:0]     charge,
    input  logic signed [63:0]     current,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending,
    output int                     checked
);

    typedef logic signed [63:0] fx_t;

    typedef struct {
        logic [31:0] idx;
        fx_t         q;
        fx_t         i;
    } step_rpt_t;

    localparam int  LUT_DEPTH = 1024;
    localparam int  LUT_IW    = $clog2(LUT_DEPTH + 1);
    localparam int  LUT_PW    = 30 + LUT_IW;
    localparam fx_t ONE_SIXTH = 64'sd715827883;

    logic [31:0] sine_lut [0:LUT_DEPTH];

    fx_t         dt_reg, inv_l_reg, inv_lc_reg, rl_reg, amp_reg;
    logic [30:0] phase_inc;
    fx_t         q_acc, i_acc;
    logic [31:0] phase_acc, step_cnt;

    step_rpt_t   expected_steps [$];

    function automatic fx_t fx_mul(input fx_t a, input fx_t b, input int sh);
        logic signed [127:0] wa, wb, p;
        wa = a;
        wb = b;
        p  = (wa * wb) >>> sh;
        if (p[127:63] == '0 || p[127:63] == '1)
            return p[63:0];
        return p[127] ? SAT_MIN : SAT_MAX;
    endfunction

    function automatic fx_t fx_add(input fx_t a, input fx_t b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? SAT_MIN : SAT_MAX;
        return s[63:0];
    endfunction

    function automatic fx_t fx_sub(input fx_t a, input fx_t b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? SAT_MIN : SAT_MAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic fx_t sine_q30(input logic [31:0] ph);
        logic [LUT_PW-1:0] scaled;
        logic [LUT_IW-1:0] k;
        fx_t               v;
        scaled = LUT_PW'(ph[29:0]) * LUT_PW'(LUT_DEPTH) + LUT_PW'(64'd536870912);
        k      = scaled[LUT_PW-1:30];
        if (k > LUT_IW'(LUT_DEPTH))
            k = LUT_IW'(LUT_DEPTH);
        if (ph[30])
            k = LUT_IW'(LUT_DEPTH) - k;
        v = {32'd0, sine_lut[k]};
        return ph[31] ? -v : v;
    endfunction

    function automatic fx_t slope_i(input fx_t q, input fx_t i, input fx_t v);
        fx_t a;
        a = fx_mul(v, inv_l_reg, 32);
        a = fx_sub(a, fx_mul(q, inv_lc_reg, 32));
        return fx_sub(a, fx_mul(i, rl_reg, 32));
    endfunction

    function automatic fx_t weigh(input fx_t k1, input fx_t k2, input fx_t k3, input fx_t k4);
        fx_t s;
        s = fx_add(k1, fx_add(k2, k2));
        return fx_add(fx_add(s, fx_add(k3, k3)), k4);
    endfunction

    initial
    begin
        logic [63:0] stp, rem, x, x2, term, sum, rounded;
        stp = PI_HALF_Q62 / 64'(LUT_DEPTH);
        rem = PI_HALF_Q62 % 64'(LUT_DEPTH);
        for (int k = 0; k <= LUT_DEPTH; k++)
        begin
            x    = stp * 64'(k) + (rem * 64'(k)) / 64'(LUT_DEPTH);
            x2   = q62_mul(x, x);
            term = x;
            sum  = x;
            for (int n = 1; n <= 12; n++)
            begin
                term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            rounded     = sum + 64'h8000_0000;
            sine_lut[k] = rounded[63:32];
        end
    end

    // advance the circuit one RK4 step and queue the pre-update report
    task automatic advance_circuit(input logic clr);
        fx_t q, i, dt, h, dt6, v0, vh, v1;
        fx_t k1q, k1i, k2q, k2i, k3q, k3i, k4q, k4i;
        step_rpt_t r;
        if (clr)
        begin
            q_acc     = '0;
            i_acc     = '0;
            phase_acc = '0;
            step_cnt  = '0;
        end
        q = q_acc;
        i = i_acc;
        r.idx = step_cnt;
        r.q   = q;
        r.i   = i;
        expected_steps.push_back(r);

        dt  = dt_reg;
        h   = dt_reg >>> 1;
        dt6 = fx_mul(dt, ONE_SIXTH, 32);
        v0  = fx_mul(amp_reg, sine_q30(phase_acc), 30);
        vh  = fx_mul(amp_reg, sine_q30(phase_acc + {1'b0, phase_inc}), 30);
        v1  = fx_mul(amp_reg, sine_q30(phase_acc + {phase_inc, 1'b0}), 30);

        k1q = i;
        k1i = slope_i(q, i, v0);
        k2q = fx_add(i, fx_mul(h, k1i, 32));
        k2i = slope_i(fx_add(q, fx_mul(h, k1q, 32)), k2q, vh);
        k3q = fx_add(i, fx_mul(h, k2i, 32));
        k3i = slope_i(fx_add(q, fx_mul(h, k2q, 32)), k3q, vh);
        k4q = fx_add(i, fx_mul(dt, k3i, 32));
        k4i = slope_i(fx_add(q, fx_mul(dt, k3q, 32)), k4q, v1);

        q_acc     = fx_add(q, fx_mul(dt6, weigh(k1q, k2q, k3q, k4q), 32));
        i_acc     = fx_add(i, fx_mul(dt6, weigh(k1i, k2i, k3i, k4i), 32));
        phase_acc = phase_acc + {phase_inc, 1'b0};
        step_cnt  = step_cnt + 32'd1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        step_rpt_t e;
        if (!rst_n)
        begin
            dt_reg     = {1'b0, RST_TIME_STEP};
            inv_l_reg  = {1'b0, RST_INV_INDUCTANCE};
            inv_lc_reg = {1'b0, RST_INV_LC};
            rl_reg     = {1'b0, RST_R_OVER_L};
            amp_reg    = {1'b0, RST_DRIVE_AMP};
            phase_inc  = RST_PHASE_STEP;
            q_acc      = '0;
            i_acc      = '0;
            phase_acc  = '0;
            step_cnt   = '0;
            expected_steps.delete();
            fail_count = 0;
            checked    = 0;
        end
        else
        begin
            if (cfg_write_en)
                case (cfg_index)
                    CFG_TIME_STEP:      dt_reg     = {1'b0, cfg_data};
                    CFG_INV_INDUCTANCE: inv_l_reg  = {1'b0, cfg_data};
                    CFG_INV_LC:         inv_lc_reg = {1'b0, cfg_data};
                    CFG_R_OVER_L:       rl_reg     = {1'b0, cfg_data};
                    CFG_DRIVE_AMP:      amp_reg    = {1'b0, cfg_data};
                    CFG_PHASE_STEP:     phase_inc  = cfg_data[30:0];
                    default: ;
                endcase
            if (in_valid && in_ready)
                advance_circuit(restart);
            if (out_valid && out_ready)
            begin
                checked++;
                if (expected_steps.size() == 0)
                begin
                    $error("result beat with no step pending");
                    fail_count++;
                end
                else
                begin
                    e = expected_steps.pop_front();
                    if (step_index !== e.idx)
                    begin
                        $error("step_index exp %0d got %0d", e.idx, step_index);
                        fail_count++;
                    end
                    if (charge !== e.q)
                    begin
                        $error("charge exp %0d got %0d", e.q, charge);
                        fail_count++;
                    end
                    if (current !== e.i)
                    begin
                        $error("current exp %0d got %0d", e.i, current);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_steps.size();
    end

endmodule

>>> tb/sv/tb_rk4_driven_rlc_circuit_step.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rk4_driven_rlc_circuit_step
// Drives RK4 step requests in random bursts across several register settings
// (defaults, realistic, full random, saturating extremes); the checker scores.
// ----------------------------------------------------------------------------
module tb_rk4_driven_rlc_circuit_step;
    import rk4rlc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam logic [62:0]            REG_MAX     = '1;
    localparam int                     SETTLE_CYC  = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   restart;
    logic                   out_valid;
    logic                   out_ready;
    logic [31:0]            step_index;
    logic signed [63:0]     charge;
    logic signed [63:0]     current;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count, pending, checked;
    int steps_sent, reg_sets;

    rk4_driven_rlc_circuit_step dut (.*);

    rk4_rlc_checker chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .restart(restart), .out_valid(out_valid), .out_ready(out_ready),
        .step_index(step_index), .charge(charge), .current(current),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: stall pattern switches between four randomly picked modes
    initial
    begin
        int mode;
        out_ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat (64)
            begin
                @(negedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic logic [62:0] rand63();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[63:1];
    endfunction

    task automatic send_step(input logic clr);
        @(negedge clk);
        in_valid <= 1'b1;
        restart  <= clr;
        do @(posedge clk); while (!in_ready);
        steps_sent++;
    endtask

    task automatic pause_sender(input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            restart  <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // wait for every report, then let the in-flight update finish
    task automatic drain();
        pause_sender(1);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [62:0] val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
    endtask

    task automatic reg_done();
        @(negedge clk);
        cfg_write_en <= 1'b0;
        reg_sets++;
    endtask

    task automatic load_regs(input int kind);
        logic [62:0] v [6];
        for (int r = 0; r < 6; r++)
            case (kind)
                0: v[r] = $urandom_range(0, 1) ? REG_MAX : '0;
                1: v[r] = rand63();
                default: v[r] = 63'($urandom_range(1, 32'hFFFF_FFFF)) *
                                63'($urandom_range(1, 4096));
            endcase
        if (kind >= 2)
        begin
            v[0] = 63'($urandom_range(1, 1 << 26));
            v[5] = 63'($urandom_range(0, 1 << 28));
        end
        reg_write(CFG_TIME_STEP, v[0]);
        reg_write(CFG_INV_INDUCTANCE, v[1]);
        reg_write(CFG_INV_LC, v[2]);
        reg_write(CFG_R_OVER_L, v[3]);
        reg_write(CFG_DRIVE_AMP, v[4]);
        reg_write(CFG_PHASE_STEP, v[5]);
        if ($urandom_range(0, 1))
            reg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, rand63());
        reg_done();
    endtask

    initial
    begin
        int burst;
        in_valid     = 1'b0;
        restart      = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        steps_sent   = 0;
        reg_sets     = 0;
        rst_n        = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults, a restart, saturation, all zero, phase wrap
        repeat (4) send_step(1'b0);
        send_step(1'b1);
        repeat (3) send_step(1'b0);
        drain();
        reg_write(CFG_TIME_STEP, REG_MAX);
        reg_write(CFG_INV_INDUCTANCE, REG_MAX);
        reg_write(CFG_INV_LC, REG_MAX);
        reg_write(CFG_R_OVER_L, REG_MAX);
        reg_write(CFG_DRIVE_AMP, REG_MAX);
        reg_write(CFG_PHASE_STEP, REG_MAX);
        reg_write(CFG_SPARE_A, '0);
        reg_done();
        repeat (5) send_step(1'b0);
        send_step(1'b1);
        drain();
        reg_write(CFG_TIME_STEP, '0);
        reg_write(CFG_INV_INDUCTANCE, '0);
        reg_write(CFG_INV_LC, '0);
        reg_write(CFG_R_OVER_L, '0);
        reg_write(CFG_DRIVE_AMP, '0);
        reg_write(CFG_PHASE_STEP, '0);
        reg_write(CFG_SPARE_B, REG_MAX);
        reg_done();
        repeat (3) send_step(1'b0);
        send_step(1'b1);
        drain();

        // random phases, mostly physically sensible settings
        for (int ph = 0; ph < 8; ph++)
        begin
            load_regs(ph < 2 ? ph : 2 + ph % 2);
            for (int n = 0; n < 160; n += burst)
            begin
                burst = $urandom_range(1, 8);
                repeat (burst) send_step($urandom_range(0, 15) == 0);
                pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30));
            end
            drain();
        end

        $display("%0d steps sent over %0d register settings, %0d reports checked",
                 steps_sent, reg_sets, checked);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
        begin
            if (pending != 0)
                $error("%0d reports never arrived", pending);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
